@@ hdl/serial_command_telemetry_unit_core_defines.svh @@
// assertion macros for the serial command and telemetry unit
// used by the top level only, no other dependencies
`ifndef SERIAL_COMMAND_TELEMETRY_UNIT_CORE_DEFINES_SVH
`define SERIAL_COMMAND_TELEMETRY_UNIT_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SCU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scu assertion failed");

// next-cycle implication, disabled during reset
`define SCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scu assertion failed");

`endif

@@ hdl/scu_pkg.sv @@
// types, codes and constants of the serial command and telemetry unit
// no dependencies; imported by every module of the unit but scu_queue
package scu_pkg;

    localparam int NUM_DATA_BYTES_DEF = 6;
    localparam int TIME_BITS_DEF      = 32;
    localparam int JOB_QUEUE_DEPTH    = 4;

    // configuration register indexes
    localparam logic [1:0] CFG_SYNC_VALUE = 2'd0;
    localparam logic [1:0] CFG_SLOW_PERIOD = 2'd1;
    localparam logic [1:0] CFG_FAST_PERIOD = 2'd2;

    localparam logic [7:0]  SYNC_VALUE_RST  = 8'h5A;
    localparam logic [15:0] SLOW_PERIOD_RST = 16'd1000;
    localparam logic [15:0] FAST_PERIOD_RST = 16'd20;

    // receive phases
    localparam logic [1:0] PH_SYNC = 2'd0;
    localparam logic [1:0] PH_CMD  = 2'd1;
    localparam logic [1:0] PH_LED  = 2'd2;

    // telemetry modes
    localparam logic [1:0] TM_IDLE = 2'd0;
    localparam logic [1:0] TM_TEMP = 2'd1;
    localparam logic [1:0] TM_FAST = 2'd2;

    // command bytes
    localparam logic [7:0] CMD_LED  = 8'h00;
    localparam logic [7:0] CMD_TEMP = 8'h10;
    localparam logic [7:0] CMD_FAST = 8'h11;
    localparam logic [7:0] LED_OFF  = 8'h00;
    localparam logic [7:0] LED_ON   = 8'h01;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    // first data byte of each telemetry pair
    localparam int TEMP_FIRST = 1;
    localparam int FAST_FIRST = 3;

    // input op codes
    localparam logic OP_SERVICE = 1'b0;
    localparam logic OP_WRITE   = 1'b1;

    // result kinds
    localparam logic KIND_TX  = 1'b0;
    localparam logic KIND_LED = 1'b1;

    typedef struct packed {
        logic       op;
        logic       byte_valid;
        logic [7:0] rx_byte;
        logic       ms_passed;
        logic [2:0] reg_index;
        logic [7:0] reg_value;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       led_on;
        logic       last;
    } t_out_item;

    // work handed from the front to the back
    typedef struct packed {
        logic       led_valid;
        logic       led_on;
        logic       tel_valid;
        logic [7:0] byte0;
        logic [7:0] byte1;
    } t_job;

endpackage

@@ hdl/serial_command_telemetry_unit_core.sv @@
// channel   direction  handshake                 payload
// input     in         push / full               i_in (t_in_item)
// result    out        empty / pop               o_out (t_out_item)
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// the front takes one word per cycle while the job queue is not full;
// a call with results queues one job; the back sends one result per
// cycle while its output register is free; a telemetry call gives
// four results, five with an led change
// reset is synchronous; full only rises when the job queue is full
// uses scu_pkg, scu_front, scu_queue, scu_back and the assertion macros
`include "serial_command_telemetry_unit_core_defines.svh"

module serial_command_telemetry_unit_core
    import scu_pkg::*;
#(
    parameter int NUM_DATA_BYTES = NUM_DATA_BYTES_DEF,
    parameter int TIME_BITS      = TIME_BITS_DEF,
    parameter int QUEUE_DEPTH    = JOB_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic q_push, q_pop, q_full, q_empty;
    t_job front_job, back_job;

    assign full        = q_full;
    assign o_cfg_ready = 1'b1;

    scu_front #(
        .NUM_DATA_BYTES (NUM_DATA_BYTES),
        .TIME_BITS      (TIME_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_item      (i_in),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_job       (front_job)
    );

    scu_queue #(
        .WIDTH (($bits(t_job))),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_job),
        .i_pop   (q_pop),
        .o_data  (back_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    scu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_job     (back_job),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_item    (o_out)
    );

    // a queued job always produces at least one word
    `SCU_ASSERT_IMP(a_job_not_blank, i_clk, i_rst_n, q_push, (front_job.led_valid || front_job.tel_valid))
    // the front never writes into a full queue
    `SCU_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, q_push, !q_full)
    // the back only takes a job that is there
    `SCU_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, q_pop, !q_empty)
    // a job written and not drained is waiting next cycle
    `SCU_ASSERT_NEXT(a_job_held, i_clk, i_rst_n, (q_push && !q_pop), !q_empty)

endmodule

@@ hdl/scu_queue.sv @@
// small register queue between front and back
// depends on nothing but its parameters
module scu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hdl/scu_front.sv @@
// front end: takes words, runs the receive machine, time and deadline,
// holds config and data bytes, hands jobs to the queue; uses scu_pkg
module scu_front
    import scu_pkg::*;
#(
    parameter int NUM_DATA_BYTES = NUM_DATA_BYTES_DEF,
    parameter int TIME_BITS      = TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_push,
    input  t_in_item    i_item,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_job        o_job
);

    logic [7:0]           r_sync_value;
    logic [15:0]          r_slow_period;
    logic [15:0]          r_fast_period;
    logic [1:0]           r_phase, n_phase;
    logic [1:0]           r_mode, n_mode;
    logic [TIME_BITS-1:0] r_now, n_now;
    logic [TIME_BITS-1:0] r_deadline, n_deadline;
    logic [7:0]           r_data [NUM_DATA_BYTES];

    logic                 accept, service, tick;
    logic                 passed;
    logic [1:0]           rx_mode;
    logic                 led_valid, led_on, tel_valid, tel_temp;
    logic [15:0]          period;

    assign accept  = i_push && !i_q_full;
    assign service = accept && (i_item.op == OP_SERVICE);
    assign tick    = i_item.ms_passed;
    assign n_now   = r_now + TIME_BITS'(tick);

    // deadline < now after the tick, without waiting on the increment
    assign passed = tick ? ((r_deadline <= r_now) && (r_now != '1))
                         : (r_deadline < r_now);

    always_comb begin
        n_phase   = r_phase;
        rx_mode   = r_mode;
        led_valid = 1'b0;
        led_on    = 1'b0;
        unique case (r_phase)
            PH_SYNC: begin
                if (i_item.byte_valid && i_item.rx_byte == r_sync_value) begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (i_item.byte_valid) begin
                    priority case (i_item.rx_byte)
                        CMD_LED: n_phase = PH_LED;
                        CMD_TEMP: begin
                            rx_mode = TM_TEMP;
                            n_phase = PH_SYNC;
                        end
                        CMD_FAST: begin
                            rx_mode = TM_FAST;
                            n_phase = PH_SYNC;
                        end
                        default: ; // unknown command, keep waiting
                    endcase
                end
            end
            PH_LED: begin
                if (i_item.byte_valid) begin
                    if (i_item.rx_byte == LED_OFF || i_item.rx_byte == LED_ON) begin
                        led_valid = 1'b1;
                        led_on    = i_item.rx_byte[0];
                    end
                    n_phase = PH_SYNC;
                end
            end
            default: n_phase = PH_SYNC;
        endcase
    end

    always_comb begin
        n_mode     = rx_mode;
        n_deadline = r_deadline;
        tel_valid  = 1'b0;
        tel_temp   = (rx_mode == TM_TEMP);
        period     = tel_temp ? r_slow_period : r_fast_period;
        if (passed) begin
            if (rx_mode == TM_TEMP || rx_mode == TM_FAST) begin
                tel_valid  = 1'b1;
                n_deadline = r_now + TIME_BITS'(period) + TIME_BITS'(tick);
            end else begin
                n_mode = TM_TEMP;
            end
        end
    end

    assign o_q_push        = service && (led_valid || tel_valid);
    assign o_job.led_valid = led_valid;
    assign o_job.led_on    = led_on;
    assign o_job.tel_valid = tel_valid;
    assign o_job.byte0     = tel_temp ? r_data[TEMP_FIRST] : r_data[FAST_FIRST];
    assign o_job.byte1     = tel_temp ? r_data[TEMP_FIRST + 1] : r_data[FAST_FIRST + 1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value  <= SYNC_VALUE_RST;
            r_slow_period <= SLOW_PERIOD_RST;
            r_fast_period <= FAST_PERIOD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SYNC_VALUE:  r_sync_value  <= i_cfg_data[7:0];
                CFG_SLOW_PERIOD: r_slow_period <= i_cfg_data;
                CFG_FAST_PERIOD: r_fast_period <= i_cfg_data;
                default: ; // no register there
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC;
            r_mode     <= TM_IDLE;
            r_now      <= '0;
            r_deadline <= '0;
        end else if (service) begin
            r_phase    <= n_phase;
            r_mode     <= n_mode;
            r_now      <= n_now;
            r_deadline <= n_deadline;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_DATA_BYTES; i++) begin
                r_data[i] <= '0;
            end
        end else if (accept && i_item.op == OP_WRITE) begin
            for (int i = 0; i < NUM_DATA_BYTES; i++) begin
                if (int'(i_item.reg_index) == i) begin
                    r_data[i] <= i_item.reg_value;
                end
            end
        end
    end

endmodule

@@ hdl/scu_back.sv @@
// back end: expands a job into led and serial byte words in the output
// register, one per cycle while that register is free; uses scu_pkg
module scu_back
    import scu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_job      i_job,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    localparam logic [2:0] STEP_LED = 3'd0;
    localparam logic [2:0] STEP_B0  = 3'd1;
    localparam logic [2:0] STEP_B1  = 3'd2;
    localparam logic [2:0] STEP_CR  = 3'd3;
    localparam logic [2:0] STEP_LF  = 3'd4;

    logic      r_busy;
    logic [2:0] r_step;
    t_job      r_job;
    t_out_item r_out, n_out;
    logic      r_out_valid;

    logic      out_free, advance, is_last, load;
    logic [2:0] last_step;

    assign out_free  = !r_out_valid || i_pop;
    assign advance   = r_busy && out_free;
    assign last_step = r_job.tel_valid ? STEP_LF : STEP_LED;
    assign is_last   = (r_step == last_step);
    assign load      = !i_q_empty && (!r_busy || (advance && is_last));
    assign o_q_pop   = load;
    assign o_empty   = !r_out_valid;
    assign o_item    = r_out;

    always_comb begin
        n_out.kind    = KIND_TX;
        n_out.tx_byte = '0;
        n_out.led_on  = 1'b0;
        n_out.last    = is_last;
        unique case (r_step)
            STEP_LED: begin
                n_out.kind   = KIND_LED;
                n_out.led_on = r_job.led_on;
            end
            STEP_B0: n_out.tx_byte = r_job.byte0;
            STEP_B1: n_out.tx_byte = r_job.byte1;
            STEP_CR: n_out.tx_byte = CHAR_CR;
            STEP_LF: n_out.tx_byte = CHAR_LF;
            default: n_out.tx_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_LED;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_step <= i_job.led_valid ? STEP_LED : STEP_B0;
            end else if (advance && is_last) begin
                r_busy <= 1'b0;
            end else if (advance) begin
                r_step <= r_step + 1'b1;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
